[hdl/egp_pkg.sv]
`default_nettype none

package egp_pkg;

  // exp table geometry
  localparam int ExpTableBits = 10;
  localparam int ExpTableSize = 1 << ExpTableBits;

  // fixed-point constants
  localparam int          CfgIdxW  = 3;
  localparam int          CfgDataW = 32;
  localparam logic [63:0] Ln2Q30   = 64'd744261118;
  localparam logic [16:0] Log2eQ16 = 17'd94548;
  localparam logic [22:0] R2Max    = 23'd4194304;
  localparam logic [27:0] MagMax   = 28'd134217728;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_CENTER_X    = 3'd0,
    CFG_CENTER_Y    = 3'd1,
    CFG_COS_ANGLE   = 3'd2,
    CFG_SIN_ANGLE   = 3'd3,
    CFG_AXIS_RATIO  = 3'd4,
    CFG_INV_TWO_VAR = 3'd5,
    CFG_PEAK_LEVEL  = 3'd6,
    CFG_HALF_EXTENT = 3'd7
  } cfg_idx_e;

  typedef logic [30:0] exp_tab_t [ExpTableSize];

  // rounded q0.30 product
  function automatic logic [63:0] rmul(input logic [63:0] a, input logic [63:0] b);
    return (a * b + 64'd536870912) >> 30;
  endfunction

  // 2^(-x), x in q0.30, by a series through the twelfth power with rounded products
  function automatic logic [30:0] pow2_neg(input logic [63:0] x);
    logic [63:0]        y;
    logic [63:0]        term;
    logic signed [63:0] acc;
    y    = (x * Ln2Q30 + 64'd536870912) >> 30;
    term = 64'd1 << 30;
    acc  = signed'(term);
    term = rmul(term, y) / 64'd1;  acc = acc - signed'(term);
    term = rmul(term, y) / 64'd2;  acc = acc + signed'(term);
    term = rmul(term, y) / 64'd3;  acc = acc - signed'(term);
    term = rmul(term, y) / 64'd4;  acc = acc + signed'(term);
    term = rmul(term, y) / 64'd5;  acc = acc - signed'(term);
    term = rmul(term, y) / 64'd6;  acc = acc + signed'(term);
    term = rmul(term, y) / 64'd7;  acc = acc - signed'(term);
    term = rmul(term, y) / 64'd8;  acc = acc + signed'(term);
    term = rmul(term, y) / 64'd9;  acc = acc - signed'(term);
    term = rmul(term, y) / 64'd10; acc = acc + signed'(term);
    term = rmul(term, y) / 64'd11; acc = acc - signed'(term);
    term = rmul(term, y) / 64'd12; acc = acc + signed'(term);
    if (acc < 0) begin
      acc = 64'sd0;
    end
    return 31'(acc);
  endfunction

  // table of 2^(-k/size) in q1.30
  function automatic exp_tab_t build_exp_table();
    exp_tab_t tab;
    for (int i = 0; i < ExpTableSize; i++) begin
      tab[i] = pow2_neg(64'(i) << (30 - ExpTableBits));
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

[hdl/egp_in_if.sv]
`default_nettype none

interface egp_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] x_coord;
  logic signed [31:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

`default_nettype wire

[hdl/egp_out_if.sv]
`default_nettype none

interface egp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] intensity;
  logic        inside_box;

  modport source (output valid, output intensity, output inside_box, input ready);
  modport sink   (input valid, input intensity, input inside_box, output ready);
endinterface

`default_nettype wire

[hdl/elliptical_gauss_profile_eval_top.sv]
// throughput: one sample per cycle while the output is not stalled, through the fifteen-stage arithmetic pipeline
// a stage takes a new item whenever it or a later stage is empty, or the output moves
// reset clears all stage valid bits and loads the configuration reset values
// the exp table is a constant rom read through a registered port in stage 13
`default_nettype none

module elliptical_gauss_profile_eval_top (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             cfg_we_i,
  input  wire [egp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire [egp_pkg::CfgDataW-1:0]     cfg_data_i,
  egp_in_if.sink                          in_i,
  egp_out_if.source                       out_o
);

  localparam int NumStages = 15;
  localparam egp_pkg::exp_tab_t ExpRom = egp_pkg::build_exp_table();

  // configuration registers
  logic signed [31:0] center_x_q, center_y_q;
  logic signed [15:0] cos_angle_q, sin_angle_q;
  logic [15:0]        axis_ratio_q;
  logic [31:0]        inv_two_var_q, peak_level_q;
  logic [30:0]        half_extent_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q    <= 32'sd0;
      center_y_q    <= 32'sd0;
      cos_angle_q   <= 16'sd16384;
      sin_angle_q   <= 16'sd0;
      axis_ratio_q  <= 16'd32768;
      inv_two_var_q <= 32'd65536;
      peak_level_q  <= 32'd65536;
      half_extent_q <= 31'd196608;
    end else if (cfg_we_i) begin
      unique case (egp_pkg::cfg_idx_e'(cfg_idx_i))
        egp_pkg::CFG_CENTER_X:    center_x_q    <= signed'(cfg_data_i);
        egp_pkg::CFG_CENTER_Y:    center_y_q    <= signed'(cfg_data_i);
        egp_pkg::CFG_COS_ANGLE:   cos_angle_q   <= signed'(cfg_data_i[15:0]);
        egp_pkg::CFG_SIN_ANGLE:   sin_angle_q   <= signed'(cfg_data_i[15:0]);
        egp_pkg::CFG_AXIS_RATIO:  axis_ratio_q  <= cfg_data_i[15:0];
        egp_pkg::CFG_INV_TWO_VAR: inv_two_var_q <= cfg_data_i;
        egp_pkg::CFG_PEAK_LEVEL:  peak_level_q  <= cfg_data_i;
        egp_pkg::CFG_HALF_EXTENT: half_extent_q <= cfg_data_i[30:0];
        default: ;
      endcase
    end
  end

  // stage valid bits and per-stage advance
  logic [NumStages:1] v_q;
  logic [NumStages:1] en;

  for (genvar g = 1; g <= NumStages; g++) begin : g_en
    assign en[g] = out_o.ready || !(&v_q[NumStages:g]);
  end

  assign in_i.ready = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) begin
        v_q[1] <= in_i.valid;
      end
      for (int s = 2; s <= NumStages; s++) begin
        if (en[s]) begin
          v_q[s] <= v_q[s-1];
        end
      end
    end
  end

  // payload registers
  logic signed [32:0] s1_dx_q, s1_dy_q;
  logic               s2_in_q;
  logic signed [48:0] s2_xc_q, s2_ys_q, s2_yc_q, s2_xs_q;
  logic               s3_in_q;
  logic signed [49:0] s3_u_q, s3_v_q;
  logic               s4_in_q;
  logic [36:0]        s4_au_q;
  logic [27:0]        s4_av_q;
  logic               s5_in_q;
  logic [52:0]        s5_qp_q;
  logic [27:0]        s5_av_q;
  logic               s6_in_q;
  logic [27:0]        s6_qu_q, s6_av_q;
  logic               s7_in_q;
  logic [55:0]        s7_qq_q, s7_vv_q;
  logic               s8_in_q;
  logic [39:0]        s8_s16_q;
  logic               s9_in_q;
  logic [55:0]        s9_hi_q, s9_lo_q;
  logic               s10_in_q;
  logic [22:0]        s10_r2_q;
  logic               s11_in_q;
  logic [39:0]        s11_tp_q;
  logic               s12_in_q;
  logic [22:0]        s12_t_q;
  logic               s13_in_q;
  logic [30:0]        s13_ent_q;
  logic [6:0]         s13_n_q;
  logic               s14_in_q;
  logic [62:0]        s14_prod_q;
  logic [6:0]         s14_n_q;
  logic               s14_tiny_q;
  logic               s15_in_q;
  logic [31:0]        s15_res_q;

  // stage 2: box test on offset magnitudes
  logic [32:0] dx_mag, dy_mag;
  logic        box_ok;
  assign dx_mag = s1_dx_q[32] ? unsigned'(33'(-s1_dx_q)) : unsigned'(s1_dx_q);
  assign dy_mag = s1_dy_q[32] ? unsigned'(33'(-s1_dy_q)) : unsigned'(s1_dy_q);
  assign box_ok = (dx_mag <= {2'b00, half_extent_q}) && (dy_mag <= {2'b00, half_extent_q});

  // stage 4: round rotated magnitudes to q16.16, clamp v
  logic [49:0] u_mag, v_mag;
  logic [50:0] u_rnd, v_rnd;
  logic [36:0] av_full;
  assign u_mag   = s3_u_q[49] ? unsigned'(50'(-s3_u_q)) : unsigned'(s3_u_q);
  assign v_mag   = s3_v_q[49] ? unsigned'(50'(-s3_v_q)) : unsigned'(s3_v_q);
  assign u_rnd   = {1'b0, u_mag} + 51'd8192;
  assign v_rnd   = {1'b0, v_mag} + 51'd8192;
  assign av_full = v_rnd[50:14];

  // stage 6: round q*|u| and clamp
  logic [53:0] qu_rnd;
  logic [38:0] qu_full;
  assign qu_rnd  = {1'b0, s5_qp_q} + 54'd16384;
  assign qu_full = qu_rnd[53:15];

  // stage 8: sum of squares rounded to q16.16
  logic [56:0] sq_sum;
  assign sq_sum = {1'b0, s7_qq_q} + {1'b0, s7_vv_q} + 57'd32768;

  // stage 10: r2 with clamp at 64.0
  logic [56:0] lo_rnd;
  logic [56:0] r2_full;
  assign lo_rnd  = {1'b0, s9_lo_q} + 57'd32768;
  assign r2_full = {1'b0, s9_hi_q} + {16'd0, lo_rnd[56:16]};

  // stage 12: t = r2 * log2(e), rounded
  logic [40:0] t_rnd;
  assign t_rnd = {1'b0, s11_tp_q} + 41'd32768;

  // stage 15: shift by 30+n with rounding, saturate
  logic [6:0]  sh_m1;
  logic [62:0] shifted;
  logic [34:0] half_up;
  logic [33:0] res_full;
  assign sh_m1    = s14_n_q + 7'd29;
  assign shifted  = s14_prod_q >> sh_m1;
  assign half_up  = {1'b0, shifted[33:0]} + 35'd1;
  assign res_full = half_up[34:1];

  always_ff @(posedge clk_i) begin
    // stage 1: offsets from the centre
    if (en[1]) begin
      s1_dx_q <= 33'(in_i.x_coord) - 33'(center_x_q);
      s1_dy_q <= 33'(in_i.y_coord) - 33'(center_y_q);
    end
    // stage 2: rotation products
    if (en[2]) begin
      s2_in_q <= box_ok;
      s2_xc_q <= 49'(s1_dx_q) * 49'(cos_angle_q);
      s2_ys_q <= 49'(s1_dy_q) * 49'(sin_angle_q);
      s2_yc_q <= 49'(s1_dy_q) * 49'(cos_angle_q);
      s2_xs_q <= 49'(s1_dx_q) * 49'(sin_angle_q);
    end
    // stage 3: rotated offsets
    if (en[3]) begin
      s3_in_q <= s2_in_q;
      s3_u_q  <= 50'(s2_xc_q) + 50'(s2_ys_q);
      s3_v_q  <= 50'(s2_yc_q) - 50'(s2_xs_q);
    end
    if (en[4]) begin
      s4_in_q <= s3_in_q;
      s4_au_q <= u_rnd[50:14];
      s4_av_q <= (av_full > 37'(egp_pkg::MagMax)) ? egp_pkg::MagMax : av_full[27:0];
    end
    // stage 5: axis ratio product
    if (en[5]) begin
      s5_in_q <= s4_in_q;
      s5_qp_q <= 53'(s4_au_q) * 53'(axis_ratio_q);
      s5_av_q <= s4_av_q;
    end
    if (en[6]) begin
      s6_in_q <= s5_in_q;
      s6_qu_q <= (qu_full > 39'(egp_pkg::MagMax)) ? egp_pkg::MagMax : qu_full[27:0];
      s6_av_q <= s5_av_q;
    end
    // stage 7: squares
    if (en[7]) begin
      s7_in_q <= s6_in_q;
      s7_qq_q <= 56'(s6_qu_q) * 56'(s6_qu_q);
      s7_vv_q <= 56'(s6_av_q) * 56'(s6_av_q);
    end
    if (en[8]) begin
      s8_in_q  <= s7_in_q;
      s8_s16_q <= sq_sum[55:16];
    end
    // stage 9: split product with the inverse variance
    if (en[9]) begin
      s9_in_q <= s8_in_q;
      s9_hi_q <= 56'(s8_s16_q) * 56'(inv_two_var_q[31:16]);
      s9_lo_q <= 56'(s8_s16_q) * 56'(inv_two_var_q[15:0]);
    end
    if (en[10]) begin
      s10_in_q <= s9_in_q;
      s10_r2_q <= (r2_full > 57'(egp_pkg::R2Max)) ? egp_pkg::R2Max : r2_full[22:0];
    end
    // stage 11: scale to base two
    if (en[11]) begin
      s11_in_q <= s10_in_q;
      s11_tp_q <= 40'(s10_r2_q) * 40'(egp_pkg::Log2eQ16);
    end
    if (en[12]) begin
      s12_in_q <= s11_in_q;
      s12_t_q  <= t_rnd[38:16];
    end
    // stage 13: exp rom read
    if (en[13]) begin
      s13_in_q  <= s12_in_q;
      s13_ent_q <= ExpRom[s12_t_q[15 -: egp_pkg::ExpTableBits]];
      s13_n_q   <= s12_t_q[22:16];
    end
    // stage 14: scale by peak level
    if (en[14]) begin
      s14_in_q   <= s13_in_q;
      s14_prod_q <= 63'(peak_level_q) * 63'(s13_ent_q);
      s14_n_q    <= s13_n_q;
      s14_tiny_q <= s13_n_q > 7'd32;
    end
    // stage 15: output register
    if (en[15]) begin
      s15_in_q <= s14_in_q;
      if (!s14_in_q || s14_tiny_q) begin
        s15_res_q <= 32'd0;
      end else if (|res_full[33:32]) begin
        s15_res_q <= 32'hFFFF_FFFF;
      end else begin
        s15_res_q <= res_full[31:0];
      end
    end
  end

  assign out_o.valid      = v_q[NumStages];
  assign out_o.intensity  = s15_res_q;
  assign out_o.inside_box = s15_in_q;

`ifndef SYNTH
  // a point outside the box never carries intensity
  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.inside_box) |-> (out_o.intensity == 32'd0))
    else $error("outside point with nonzero intensity");

  // input is held off only when every stage is occupied
  a_ready_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (&v_q && !out_o.ready))
    else $error("input stalled with room in the pipeline");

  // an underflowing exponent yields zero
  a_tiny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v_q[14] && en[15] && s14_tiny_q) |=> (out_o.intensity == 32'd0))
    else $error("underflow did not give zero");
`endif

endmodule

`default_nettype wire
